// ===== hdl/dsdc_pkg.sv =====
// Package: shared constants, types and controller/datapath command and status structs.
package dsdc_pkg;

    localparam int MaxRequestsDefault = 32;
    localparam int TrackW = 16;
    localparam int TotalW = 22;
    localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

    localparam logic [1:0] CfgAlgorithm  = 2'd0;
    localparam logic [1:0] CfgStartTrack = 2'd1;
    localparam logic [1:0] CfgTrackCount = 2'd2;

    localparam logic [2:0] AlgFcfs  = 3'd0;
    localparam logic [2:0] AlgSstf  = 3'd1;
    localparam logic [2:0] AlgScan  = 3'd2;
    localparam logic [2:0] AlgCscan = 3'd3;
    localparam logic [2:0] AlgLook  = 3'd4;
    localparam logic [2:0] AlgClook = 3'd5;

    // Controller to datapath.
    typedef struct packed {
        logic store;      // write accepted beat into the store
        logic scan_init;  // start a pass over the store
        logic scan_step;  // present entry at scan index, accumulate
        logic pick_done;  // SSTF: commit the best candidate of this pass
        logic finish;     // form result
        logic clear;      // empty the store for the next batch
    } dsdc_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic scan_last;  // scan index is at the final stored entry
        logic all_served; // SSTF: every request served
    } dsdc_sts_t;

endpackage

// ===== hdl/disk_seek_distance_calculator.sv =====
// Disk seek distance calculator: top level joining controller and datapath.
// Operation: loading writes each accepted beat into the store; on the closing beat one pass
// over the N stored requests runs, and SSTF runs N such passes, one per pick.
// Throughput: one request beat per cycle while loading; one batch at a time.
// Result is held on m_axis until taken; loading resumes afterwards.
// Reset (rst_n low, asynchronous) empties the store and loads register defaults.
module disk_seek_distance_calculator #(
    parameter int MAX_REQUESTS = dsdc_pkg::MaxRequestsDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] track
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [21:0] total_movement, [22] overflow
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);
    import dsdc_pkg::*;

    logic [2:0]  algorithm_reg;
    logic [15:0] start_track_reg;
    logic [16:0] track_count_reg;
    dsdc_cmd_t   cmd;
    dsdc_sts_t   sts;
    logic [TotalW-1:0] total;
    logic        ovf;

    assign cfg_ready = 1'b1;
    assign m_axis_tdata = {1'b0, ovf, total};

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            algorithm_reg   <= AlgFcfs;
            start_track_reg <= '0;
            track_count_reg <= 17'd200;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CfgAlgorithm:  algorithm_reg   <= cfg_data[2:0];
                CfgStartTrack: start_track_reg <= cfg_data[15:0];
                CfgTrackCount: track_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    dsdc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_last(s_axis_tlast), .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .algorithm(algorithm_reg), .sts(sts), .cmd(cmd)
    );

    dsdc_datapath #(.MAX_REQUESTS(MAX_REQUESTS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .track(s_axis_tdata), .algorithm(algorithm_reg),
        .start_track(start_track_reg), .track_count(track_count_reg),
        .total_movement(total), .overflow(ovf)
    );
endmodule

// ===== hdl/dsdc_datapath.sv =====
// Datapath: request store, served marks, scan unit and accumulators.
module dsdc_datapath #(
    parameter int MAX_REQUESTS = dsdc_pkg::MaxRequestsDefault
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dsdc_pkg::dsdc_cmd_t           cmd,
    output dsdc_pkg::dsdc_sts_t           sts,
    input  logic [dsdc_pkg::TrackW-1:0]   track,
    input  logic [2:0]                    algorithm,
    input  logic [15:0]                   start_track,
    input  logic [16:0]                   track_count,
    output logic [dsdc_pkg::TotalW-1:0]   total_movement,
    output logic                          overflow
);
    import dsdc_pkg::*;

    localparam int IdxW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CntW = $clog2(MAX_REQUESTS + 1);
    localparam logic [CntW-1:0] CountMax = CntW'(MAX_REQUESTS);

    logic [TrackW-1:0] mem [MAX_REQUESTS];
    logic [TrackW-1:0] rd_reg;
    logic [IdxW-1:0]   rd_idx_reg;   // index of rd_reg
    logic              rd_ok_reg;    // rd_reg holds a fresh read

    logic [CntW-1:0]   count_reg;
    logic              dropped_reg;
    logic [MAX_REQUESTS-1:0] served_reg;
    logic [IdxW-1:0]   scan_reg;
    logic [CntW-1:0]   served_cnt_reg;

    logic [TrackW-1:0] pos_reg;
    logic [23:0]       total_reg;    // wide enough for saturation check
    logic [TrackW-1:0] best_d_reg;
    logic [IdxW-1:0]   best_i_reg;
    logic [TrackW-1:0] best_t_reg;
    logic              found_reg;

    logic [TrackW-1:0] mn_reg, mx_reg, upmax_reg, lowmin_reg, lowmax_reg;
    logic              has_up_reg, has_low_reg;

    logic [TrackW-1:0] r, d;
    logic              sstf;
    assign r    = rd_reg;
    assign d    = (r > pos_reg) ? r - pos_reg : pos_reg - r;
    assign sstf = (algorithm == AlgSstf);

    assign sts.scan_last  = ({{(CntW-IdxW){1'b0}}, scan_reg} + CntW'(1)) >= count_reg;
    assign sts.all_served = (served_cnt_reg == count_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.store && count_reg != CountMax)
            mem[count_reg[IdxW-1:0]] <= track;
        rd_reg     <= mem[scan_reg];
        rd_idx_reg <= scan_reg;
    end

    // Sweep-policy result, from gathered extremes.
    logic [23:0] sweep_tot;
    logic [16:0] tc_last;
    logic [TrackW-1:0] upos;
    always_comb
    begin
        sweep_tot = '0;
        tc_last   = track_count - 17'd1;
        upos      = has_up_reg ? upmax_reg : start_track;
        if (algorithm == AlgScan || algorithm == AlgLook)
        begin
            if (start_track < mn_reg)
                sweep_tot = 24'(mx_reg - start_track);
            else if (mx_reg > start_track)
            begin
                if (algorithm == AlgScan)
                    sweep_tot = 24'(start_track) + 24'(mx_reg);
                else
                    sweep_tot = 24'(start_track - mn_reg) + 24'(mx_reg - mn_reg);
            end
            else
                sweep_tot = 24'(start_track - mn_reg);
        end
        else
        begin
            sweep_tot = 24'(upos - start_track);
            if (algorithm == AlgCscan)
            begin
                if (track_count != 17'd0 && {1'b0, upos} < tc_last)
                    sweep_tot = sweep_tot + 24'(tc_last - {1'b0, upos});
                if (has_low_reg)
                    sweep_tot = sweep_tot + 24'(lowmax_reg);
            end
            else if (has_low_reg)
                sweep_tot = sweep_tot + 24'(upos - lowmin_reg)
                          + 24'(lowmax_reg - lowmin_reg);
        end
    end

    logic sweep;
    assign sweep = (algorithm >= AlgScan) && (algorithm <= AlgClook);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            dropped_reg    <= 1'b0;
            served_reg     <= '0;
            scan_reg       <= '0;
            served_cnt_reg <= '0;
            rd_ok_reg      <= 1'b0;
            found_reg      <= 1'b0;
            total_reg      <= '0;
            pos_reg        <= '0;
        end
        else
        begin
            rd_ok_reg <= cmd.scan_step;
            if (cmd.store)
            begin
                if (count_reg != CountMax)
                    count_reg <= count_reg + CntW'(1);
                else
                    dropped_reg <= 1'b1;
            end
            if (cmd.scan_init)
            begin
                scan_reg   <= '0;
                found_reg  <= 1'b0;
                if (served_cnt_reg == '0)
                begin
                    pos_reg    <= start_track;
                    total_reg  <= '0;
                    mn_reg     <= '1; mx_reg <= '0; upmax_reg <= '0;
                    lowmin_reg <= '1; lowmax_reg <= '0;
                    has_up_reg <= 1'b0; has_low_reg <= 1'b0;
                end
            end
            if (cmd.scan_step && !sts.scan_last)
                scan_reg <= scan_reg + IdxW'(1);
            // Fold the entry read in the previous cycle.
            if (rd_ok_reg)
            begin
                if (sstf)
                begin
                    if (!served_reg[rd_idx_reg] && (!found_reg || d < best_d_reg))
                    begin
                        found_reg  <= 1'b1;
                        best_d_reg <= d;
                        best_i_reg <= rd_idx_reg;
                        best_t_reg <= r;
                    end
                end
                else if (sweep)
                begin
                    if (r < mn_reg) mn_reg <= r;
                    if (r > mx_reg) mx_reg <= r;
                    if (r >= start_track)
                    begin
                        has_up_reg <= 1'b1;
                        if (r > upmax_reg) upmax_reg <= r;
                    end
                    else
                    begin
                        has_low_reg <= 1'b1;
                        if (r < lowmin_reg) lowmin_reg <= r;
                        if (r > lowmax_reg) lowmax_reg <= r;
                    end
                end
                else
                begin
                    total_reg <= total_reg + 24'(d);
                    pos_reg   <= r;
                end
            end
            if (cmd.pick_done)
            begin
                total_reg              <= total_reg + 24'(best_d_reg);
                pos_reg                <= best_t_reg;
                served_reg[best_i_reg] <= 1'b1;
                served_cnt_reg         <= served_cnt_reg + CntW'(1);
            end
            if (cmd.finish)
            begin
                logic [23:0] t;
                t = sweep ? sweep_tot : total_reg;
                total_movement <= (t > 24'(TotalMax)) ? TotalMax : t[TotalW-1:0];
                overflow       <= dropped_reg;
            end
            if (cmd.clear)
            begin
                count_reg      <= '0;
                dropped_reg    <= 1'b0;
                served_reg     <= '0;
                served_cnt_reg <= '0;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CountMax)
        else $error("request count beyond capacity");
    assert property (@(posedge clk) disable iff (!rst_n) cmd.pick_done |-> found_reg)
        else $error("SSTF pick without candidate");
    assert property (@(posedge clk) disable iff (!rst_n) served_cnt_reg <= count_reg)
        else $error("served more than stored");
endmodule

// ===== hdl/dsdc_ctrl.sv =====
// Controller: sequences loading, store passes and result hand-off.
module dsdc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  logic [2:0]           algorithm,
    input  dsdc_pkg::dsdc_sts_t  sts,
    output dsdc_pkg::dsdc_cmd_t  cmd
);
    import dsdc_pkg::*;

    typedef enum logic [2:0] {LOAD, SCAN, DRAIN, PICK, RESCAN, DONE, HOLD} state_t;
    state_t state_reg;
    logic   accept;

    assign in_ready  = (state_reg == LOAD);
    assign out_valid = (state_reg == HOLD);
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        cmd = '0;
        cmd.store = accept;
        case (state_reg)
            LOAD:    cmd.scan_init = accept && in_last;
            SCAN:    cmd.scan_step = 1'b1;
            PICK:    begin cmd.pick_done = 1'b1; end
            RESCAN:  cmd.scan_init = !sts.all_served;
            DONE:    begin cmd.finish = 1'b1; cmd.clear = 1'b1; end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= LOAD;
        else
        begin
            case (state_reg)
                LOAD:    if (accept && in_last) state_reg <= SCAN;
                SCAN:    if (sts.scan_last) state_reg <= DRAIN;
                DRAIN:   state_reg <= (algorithm == AlgSstf) ? PICK : DONE;
                PICK:    state_reg <= RESCAN;
                RESCAN:  state_reg <= sts.all_served ? DONE : SCAN;
                DONE:    state_reg <= HOLD;
                HOLD:    if (out_ready) state_reg <= LOAD;
                default: state_reg <= LOAD;
            endcase
        end
    end

    // After a pick, start another pass only while unserved requests remain.
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
        else $error("load and result overlap");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == HOLD && !out_ready) |=> state_reg == HOLD)
        else $error("result dropped");
    assert property (@(posedge clk) disable iff (!rst_n) cmd.pick_done |-> !cmd.finish)
        else $error("pick and finish together");
endmodule

// ===== bench/disk_seek_distance_calculator_tb.sv =====
// Self-checking bench for the disk seek distance calculator: directed table plus random batches.
`timescale 1ns / 100ps

module disk_seek_distance_calculator_tb;
    import dsdc_pkg::*;

    localparam int NReq = 32;
    localparam int LimitCycles = 2000000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] track
    logic        s_axis_tlast;   // last
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [21:0] total_movement, [22] overflow
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_data;

    disk_seek_distance_calculator dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    typedef struct packed {
        logic [21:0] total;
        logic        ovf;
    } seek_res_t;

    // Shadow of the block's registers and request store.
    logic [2:0]  sh_alg;
    logic [15:0] sh_start;
    logic [16:0] sh_tracks;
    logic [15:0] pend_q[$];
    logic        pend_drop;

    seek_res_t   seek_q[$];
    int          errors;
    int          cycles;
    bit          stall_rx;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Total head travel for the pending batch under the shadow policy.
    function automatic logic [21:0] seek_total();
        longint unsigned tot;
        int n, i, j, pick;
        longint unsigned pos, best, d, s, mn, mx, upmax, lowmin, lowmax;
        bit has_up, has_low, found;
        bit done[NReq];
        tot = 0;
        n = pend_q.size();
        s = sh_start;
        pos = s;
        if (sh_alg == AlgSstf)
        begin
            for (j = 0; j < NReq; j++) done[j] = 1'b0;
            for (i = 0; i < n; i++)
            begin
                found = 0; best = 0; pick = 0;
                for (j = 0; j < n; j++)
                begin
                    if (!done[j])
                    begin
                        d = (pend_q[j] > pos) ? pend_q[j] - pos : pos - pend_q[j];
                        if (!found || d < best)
                        begin
                            best = d; pick = j; found = 1;
                        end
                    end
                end
                tot += best; pos = pend_q[pick]; done[pick] = 1'b1;
            end
        end
        else if (sh_alg >= AlgScan && sh_alg <= AlgClook)
        begin
            mn = 64'hFFFFFFFF; mx = 0; upmax = 0; lowmin = 64'hFFFFFFFF; lowmax = 0;
            has_up = 0; has_low = 0;
            for (i = 0; i < n; i++)
            begin
                d = pend_q[i];
                if (d < mn) mn = d;
                if (d > mx) mx = d;
                if (d >= s)
                begin
                    has_up = 1; if (d > upmax) upmax = d;
                end
                else
                begin
                    has_low = 1;
                    if (d < lowmin) lowmin = d;
                    if (d > lowmax) lowmax = d;
                end
            end
            if (sh_alg == AlgScan || sh_alg == AlgLook)
            begin
                if (s < mn) tot = mx - s;
                else if (mx > s) tot = (sh_alg == AlgScan) ? s + mx : (s - mn) + (mx - mn);
                else tot = s - mn;
            end
            else
            begin
                pos = has_up ? upmax : s;
                tot = pos - s;
                if (sh_alg == AlgCscan)
                begin
                    if (sh_tracks > 0 && pos < sh_tracks - 1) tot += sh_tracks - 1 - pos;
                    if (has_low) tot += lowmax;
                end
                else if (has_low) tot += (pos - lowmin) + (lowmax - lowmin);
            end
        end
        else
        begin
            // FCFS, also for the two undefined policy codes
            for (i = 0; i < n; i++)
            begin
                tot += (pend_q[i] > pos) ? pend_q[i] - pos : pos - pend_q[i];
                pos = pend_q[i];
            end
        end
        if (tot > TotalMax) tot = TotalMax;
        return tot[21:0];
    endfunction

    // Feed one request into the shadow; on a closing beat queue the result.
    task automatic note_request(input logic [15:0] trk, input logic lst);
        seek_res_t r;
        if (pend_q.size() < NReq) pend_q.push_back(trk);
        else pend_drop = 1'b1;
        if (lst)
        begin
            r.total = seek_total();
            r.ovf = pend_drop;
            seek_q.push_back(r);
            pend_q.delete();
            pend_drop = 1'b0;
        end
    endtask

    // Drive one beat and hold it until taken; gap before it comes from the burst logic.
    task automatic send_request(input logic [15:0] trk, input logic lst);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= trk;
        s_axis_tlast  <= lst;
        do @(posedge clk); while (!s_axis_tready);
        note_request(trk, lst);
        @(negedge clk);
    endtask

    int burst_left;
    task automatic pace();
        int g;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (g > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (g) @(negedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CfgAlgorithm:  sh_alg = val[2:0];
            CfgStartTrack: sh_start = val[15:0];
            CfgTrackCount: sh_tracks = val;
            default:       ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Hold off until every expected result has drained, then let the block settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (seek_q.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Receiver: stall on its own pattern, quiet stretches included.
    always @(negedge clk)
    begin
        if (cycles % 512 < 128) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 2) != 0);
    end

    // Check each result beat against the oldest expectation.
    always @(posedge clk)
    begin
        seek_res_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.total = m_axis_tdata[21:0];
            got.ovf   = m_axis_tdata[22];
            if (seek_q.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result total=%0d ovf=%0b", got.total, got.ovf);
            end
            else
            begin
                want = seek_q.pop_front();
                if (got.total !== want.total || got.ovf !== want.ovf || m_axis_tdata[23] !== 1'b0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected total=%0d ovf=%0b, got total=%0d ovf=%0b",
                                  want.total, want.ovf, got.total, got.ovf);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LimitCycles)
        begin
            $display("disk_seek_distance_calculator regression: fail");
            $finish;
        end
    end

    // Directed table: track, last, whether a fixed answer applies, and that answer.
    typedef struct {
        logic [15:0] trk;
        logic        lst;
        bit          fixed;
        logic [21:0] total;
    } req_row_t;

    req_row_t dir_rows[] = '{
        '{16'd0,     1'b1, 1'b1, 22'd0},      // after reset, FCFS from track 0
        '{16'hFFFF,  1'b1, 1'b1, 22'd65535},  // highest track
        '{16'hAAAA,  1'b0, 1'b0, 22'd0},
        '{16'h5555,  1'b0, 1'b0, 22'd0},
        '{16'h0001,  1'b1, 1'b0, 22'd0}
    };

    int i, k, n, alg, len;
    logic [15:0] t;

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tlast = 1'b0;
        m_axis_tready = 1'b1;
        cfg_valid = 1'b0; cfg_index = CfgAlgorithm; cfg_data = '0;
        errors = 0; cycles = 0; burst_left = 0;
        sh_alg = AlgFcfs; sh_start = '0; sh_tracks = 17'd200;
        pend_drop = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Rows with a fixed answer replace the predicted total of their result.
        for (k = 0; k < dir_rows.size(); k++)
        begin
            send_request(dir_rows[k].trk, dir_rows[k].lst);
            if (dir_rows[k].fixed && dir_rows[k].lst)
                seek_q[seek_q.size() - 1].total = dir_rows[k].total;
        end
        s_axis_tvalid <= 1'b0;
        drain();

        // Every policy, including the undefined codes, on one odd batch.
        for (alg = 0; alg < 8; alg++)
        begin
            write_reg(CfgAlgorithm, alg[16:0]);
            write_reg(CfgStartTrack, 17'd100);
            send_request(16'd150, 1'b0);
            send_request(16'd20, 1'b0);
            send_request(16'd100, 1'b1);
            drain();
        end
        // C-SCAN with head past the last track, and with zero track count.
        write_reg(CfgAlgorithm, {14'd0, AlgCscan});
        write_reg(CfgTrackCount, 17'd10);
        send_request(16'd50, 1'b0);
        send_request(16'd3, 1'b1);
        drain();
        write_reg(CfgTrackCount, 17'd0);
        send_request(16'd50, 1'b1);
        drain();
        // Overflowing batch, closing beat dropped too.
        write_reg(CfgAlgorithm, {14'd0, AlgFcfs});
        for (k = 0; k < NReq + 2; k++) send_request((k & 1) ? 16'hFFFF : 16'h0000, k == NReq + 1);
        drain();

        // Random part: batches of mostly small size, registers changed between phases.
        n = 0;
        while (n < 400)
        begin
            write_reg(CfgAlgorithm, 17'($urandom_range(0, 7)));
            case ($urandom_range(0, 3))
                0: write_reg(CfgStartTrack, 17'd0);
                1: write_reg(CfgStartTrack, 17'hFFFF);
                default: write_reg(CfgStartTrack, 17'($urandom_range(0, 65535)));
            endcase
            case ($urandom_range(0, 4))
                0: write_reg(CfgTrackCount, 17'h10000);
                1: write_reg(CfgTrackCount, 17'd1);
                2: write_reg(CfgTrackCount, 17'd0);
                default: write_reg(CfgTrackCount, 17'($urandom_range(1, 65536)));
            endcase
            for (k = 0; k < 6; k++)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 8);
                for (i = 0; i < len; i++)
                begin
                    pace();
                    t = 16'($urandom_range(0, 65535));
                    if ($urandom_range(0, 3) == 0) t = 16'($urandom_range(0, 255));
                    send_request(t, i == len - 1);
                    n++;
                end
            end
            drain();
        end

        drain();
        repeat (50) @(negedge clk);
        if (errors == 0 && seek_q.size() == 0)
            $display("disk_seek_distance_calculator regression: pass");
        else
            $display("disk_seek_distance_calculator regression: fail");
        $finish;
    end

endmodule
